[rtl/core/bdq_pkg.sv]
// Shared types and constants for the bounded deque with indexed read.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 7;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP_FRONT = 2'd1,
    CMD_POP_BACK  = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

[rtl/core/bdq_cmd_if.sv]
// Command channel: valid/ready handshake with the command payload.
`timescale 1ns / 1ps
interface bdq_cmd_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] push_value;
  logic [IDX_W-1:0]         read_index;

  modport source (output valid, output command, output push_value, output read_index,
                  input ready);
  modport sink   (input valid, input command, input push_value, input read_index,
                  output ready);
endinterface

[rtl/core/bdq_rsp_if.sv]
// Response channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       element_count;

  modport source (output valid, output read_value, output status, output element_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input element_count,
                  output ready);
endinterface

[rtl/core/bdq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bounded_deque_indexed_read.sv]
// Top level: bounded deque of signed 32-bit words with indexed read.
//
// Usage:
//   cmd_i carries one command per transfer: push at back, pop front, pop back
//   or read at an index counted from the front. rsp_o returns exactly one
//   result per command, in order: read value (zero unless a good read),
//   status (ok, empty, full, out of range) and the element count after it.
//   A rejected command leaves the contents, pointer and count untouched.
//
// Pipeline and throughput:
//   A result reaches rsp_o through stage one and the output register: the RAM
//   read and the stage-one fields register at the command transfer edge, the
//   output register loads when stage one advances. Pointer and count update at
//   the command transfer itself, so a new command can be taken every cycle
//   while rsp_o is not held off.
//
// Reset: front pointer and count clear, both channels go idle. RAM
//   contents are left as they are; only written entries are ever read.
// Stall: when rsp_o is held off, the output register keeps its result,
//   one more command may sit behind it at the RAM output, and then
//   cmd_i.ready drops until the receiver takes a transfer.
`timescale 1ns / 1ps
module bounded_deque_indexed_read #(
  parameter int CAPACITY = 128
) (
  input logic      clk_i,
  input logic      rst_ni,
  bdq_cmd_if.sink  cmd_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 1;
  localparam int XW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] CapP = PW'(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef struct packed {
    status_e       status;
    logic [CW-1:0] count;
    logic          rd_ok;
  } s1_t;

  function automatic logic [AW-1:0] ring_pos(logic [PW-1:0] base, logic [PW-1:0] off);
    logic [PW-1:0] p;
    p = base + off;
    if (p >= CapP) begin
      p = p - CapP;
    end
    return p[AW-1:0];
  endfunction

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          s1_valid_q;
  s1_t           s1_q, s1_d;
  logic          out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  status_e       out_status_q;
  logic [CW-1:0] out_count_q;

  logic          accept, advance, in_ready;
  cmd_e          cmd;
  status_e       status;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;

  assign cmd      = cmd_e'(cmd_i.command);
  assign advance  = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready = !s1_valid_q || advance;
  assign accept   = cmd_i.valid && in_ready;
  assign cmd_i.ready = in_ready;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    status  = ST_OK;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = ring_pos(PW'(front_q), PW'(count_q));
    raddr   = ring_pos(PW'(front_q), PW'(cmd_i.read_index));
    case (cmd)
      CMD_PUSH: begin
        if (count_q == CapC) begin
          status = ST_FULL;
        end else begin
          we      = accept;
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          front_d = ring_pos(PW'(front_q), PW'(1));
          count_d = count_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (XW'(cmd_i.read_index) >= XW'(count_q)) begin
          status = ST_RANGE;
        end else begin
          re = accept;
        end
      end
      default: status = ST_OK;
    endcase
    s1_d.status = status;
    s1_d.count  = count_d;
    s1_d.rd_ok  = (cmd == CMD_READ) && (status == ST_OK);
  end

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.push_value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (advance) begin
      out_value_q  <= s1_q.rd_ok ? rdata : '0;
      out_status_q <= s1_q.status;
      out_count_q  <= s1_q.count;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_value    = out_value_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.element_count = COUNT_W'(out_count_q);

  // RAM output must hold while the result behind the output register waits
  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> $stable(rdata))
    else $error("RAM read data changed under a stalled result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("element count above capacity");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_PUSH && count_q != CapC) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted push did not advance the count");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !rsp_o.ready) |-> !cmd_i.ready)
    else $error("command taken with both result stages full");

  a_write_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("RAM read and write issued for one command");

endmodule

[dv/tb_top.sv]
// Testbench for the bounded deque: scoreboard, command and response drivers.
`timescale 1ns / 1ps
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH     = 128;
  localparam int ITEMS     = 1650;
  localparam int HOLD_CYC  = 300;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
  } deque_rsp_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_READ} mix_e;

  // Mirror of the deque contents; one expected result per accepted command.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned fill;
    deque_rsp_t  result_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned peak_fill;
    int unsigned head_wraps;
    int unsigned cmd_seen[4];
    int unsigned status_seen[4];

    function int unsigned slot(int unsigned offset);
      int unsigned p;
      p = head + offset;
      if (p >= DEPTH) p -= DEPTH;
      return p;
    endfunction

    function void apply_cmd(cmd_e cmd, logic signed [DATA_W-1:0] value,
                            logic [IDX_W-1:0] idx);
      deque_rsp_t r;
      r.value  = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ring[slot(fill)] = value;
            fill++;
          end
        end
        CMD_POP_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            head = slot(1);
            if (head == 0) head_wraps++;
            fill--;
          end
        end
        CMD_POP_BACK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else fill--;
        end
        default: begin
          if (idx >= fill) r.status = ST_RANGE;
          else r.value = ring[slot(idx)];
        end
      endcase
      r.count = COUNT_W'(fill);
      cmd_seen[cmd]++;
      status_seen[r.status]++;
      if (fill > peak_fill) peak_fill = fill;
      result_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH #%0d: %s", errors, what);
    endtask

    task check_rsp(logic signed [DATA_W-1:0] value, logic [STAT_W-1:0] status,
                   logic [COUNT_W-1:0] count);
      deque_rsp_t want;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %0d status %0d count %0d",
                                  value, status, count));
        return;
      end
      want = result_q.pop_front();
      checked++;
      if (value !== want.value)
        report_mismatch($sformatf("result %0d read_value %0d, want %0d",
                                  checked, value, want.value));
      if (status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  checked, status, want.status));
      if (count !== want.count)
        report_mismatch($sformatf("result %0d element_count %0d, want %0d",
                                  checked, count, want.count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bdq_cmd_if cmd_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_indexed_read #(.CAPACITY(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  deque_scoreboard sb = new();

  int unsigned n_sent    = 0;
  int unsigned burst_left = 0;
  bit          no_gaps   = 1'b0;
  bit          hold_req  = 1'b0;
  bit          draining  = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_PUSH;
    cmd_if.push_value = '0;
    cmd_if.read_index = '0;
  end

  // Offer one command, wait for the transfer, then pace the sender in bursts.
  task automatic send_cmd(cmd_e cmd, logic signed [DATA_W-1:0] value,
                          logic [IDX_W-1:0] idx);
    int unsigned gap;
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.push_value <= value;
    cmd_if.read_index <= idx;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    sb.apply_cmd(cmd, value, idx);
    n_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_random(mix_e mix);
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         idx;
    int unsigned              roll;
    int unsigned              push_pct;
    int unsigned              popf_pct;
    int unsigned              popb_pct;
    case (mix)
      MIX_FILL:  begin push_pct = 80; popf_pct = 86; popb_pct = 90; end
      MIX_DRAIN: begin push_pct = 12; popf_pct = 50; popb_pct = 85; end
      MIX_EVEN:  begin push_pct = 30; popf_pct = 50; popb_pct = 70; end
      default:   begin push_pct = 20; popf_pct = 28; popb_pct = 36; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) cmd = CMD_PUSH;
    else if (roll < popf_pct) cmd = CMD_POP_FRONT;
    else if (roll < popb_pct) cmd = CMD_POP_BACK;
    else cmd = CMD_READ;
    case ($urandom_range(0, 15))
      0:       value = 32'sh7FFF_FFFF;
      1:       value = 32'sh8000_0000;
      2:       value = '0;
      3:       value = -32'sd1;
      default: value = $urandom;
    endcase
    // Mostly in-range reads, some anywhere across the index field.
    if (sb.fill > 0 && $urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, sb.fill - 1));
    else idx = IDX_W'($urandom_range(0, 127));
    send_cmd(cmd, value, idx);
  endtask

  // Response side: checks every transfer, stalls on its own pattern.
  initial begin : rsp_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    rsp_if.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_rsp(rsp_if.read_value, rsp_if.status, rsp_if.element_count);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (draining) begin
        rsp_if.ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (mode_left % 8 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned next_hold;
    int unsigned steps;
    int unsigned waited;
    mix_e        mix;
    deque_rsp_t  left;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty rejects, extreme values, reads at edges, pops from both ends.
    burst_left = 30;
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_READ, '0, 7'd0);
    send_cmd(CMD_PUSH, 32'sh7FFF_FFFF, '0);
    send_cmd(CMD_PUSH, 32'sh8000_0000, 7'd127);
    send_cmd(CMD_PUSH, '0, '0);
    send_cmd(CMD_PUSH, -32'sd1, '0);
    send_cmd(CMD_READ, '0, 7'd0);
    send_cmd(CMD_READ, '0, 7'd3);
    send_cmd(CMD_READ, '0, 7'd4);
    send_cmd(CMD_READ, '0, 7'd127);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_READ, '0, 7'd0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_READ, '0, 7'd1);
    send_cmd(CMD_PUSH, 32'sh5A5A_A5A5, '0);
    send_cmd(CMD_READ, '0, 7'd2);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_READ, '0, 7'd127);

    // Random phases; the first one pushes until the deque is full or its step limit is hit.
    next_hold = n_sent;
    mix = MIX_FILL;
    while (n_sent < ITEMS) begin
      if (n_sent >= next_hold) begin
        // Receiver holds off while the sender keeps offering back to back.
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (40) send_random(MIX_EVEN);
        no_gaps   = 1'b0;
        next_hold = (next_hold < ITEMS / 2) ? ITEMS / 2 : 32'hFFFF_FFFF;
      end
      steps = 0;
      case (mix)
        MIX_FILL: begin
          while (sb.fill < DEPTH && steps < 400 && n_sent < ITEMS) begin
            send_random(MIX_FILL);
            steps++;
          end
          repeat ($urandom_range(2, 6)) send_cmd(CMD_PUSH, $urandom, IDX_W'($urandom));
          repeat ($urandom_range(4, 10)) send_random(MIX_READ);
        end
        MIX_DRAIN: begin
          while (sb.fill > 0 && steps < 400 && n_sent < ITEMS) begin
            send_random(MIX_DRAIN);
            steps++;
          end
          send_cmd(CMD_POP_FRONT, $urandom, IDX_W'($urandom));
          send_cmd(CMD_POP_BACK, $urandom, IDX_W'($urandom));
          send_cmd(CMD_READ, $urandom, IDX_W'($urandom));
        end
        default: repeat ($urandom_range(50, 150)) send_random(mix);
      endcase
      mix = mix_e'($urandom_range(0, 3));
    end

    cmd_if.valid <= 1'b0;
    draining = 1'b1;
    waited = 0;
    while (sb.result_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    while (sb.result_q.size() != 0) begin
      left = sb.result_q.pop_front();
      sb.report_mismatch($sformatf("no result for expected status %0d count %0d",
                                   left.status, left.count));
    end

    $display("run: %0d commands (push %0d, pop front %0d, pop back %0d, read %0d), %0d checked",
             n_sent, sb.cmd_seen[CMD_PUSH], sb.cmd_seen[CMD_POP_FRONT],
             sb.cmd_seen[CMD_POP_BACK], sb.cmd_seen[CMD_READ], sb.checked);
    $display("run: rejects full %0d, empty %0d, range %0d; peak fill %0d, front wraps %0d",
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE],
             sb.peak_fill, sb.head_wraps);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_cmd_if.sv
rtl/core/bdq_rsp_if.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_deque_indexed_read.sv
dv/tb_top.sv
